// ===== hw/rtl/odr_pkg.sv =====
// ----------------------------------------------------------------------------
// odr_pkg
// Shared types, constants and the quarter-wave sine table for the
// dead-reckoning odometry integrator.
// ----------------------------------------------------------------------------
`default_nettype none

package odr_pkg;

  // Field widths
  localparam int POS_W   = 48;  // position, 16 fraction bits
  localparam int CNT_W   = 32;  // encoder count
  localparam int HD_W    = 16;  // heading, centidegrees
  localparam int PITCH_W = 15;  // pitch, centidegrees, signed
  localparam int DPC_W   = 32;  // distance per count, 2^-32 units
  localparam int CMD_W   = 2;

  localparam logic [DPC_W-1:0] DPC_RESET = 32'd1030718;

  // Quarter-wave sine table: SIN_DEPTH+1 entries, Q1.15, values 0..32768
  localparam int SIN_DEPTH = 1024;
  localparam int SIN_W     = 16;
  localparam int TRIG_W    = SIN_W + 1;  // signed trig value
  localparam int ADDR_W    = $clog2(SIN_DEPTH + 1);

  // Angle arithmetic in centidegrees
  localparam int ANG_W     = 16;
  localparam int ANG_QUAD  = 9000;
  localparam int ANG_HALF  = 18000;
  localparam int ANG_3Q    = 27000;
  localparam int ANG_FULL  = 36000;
  localparam int IDX_RND   = ANG_QUAD / 2;
  localparam int QR_W      = $clog2(ANG_QUAD);

  // Index numerator r*SIN_DEPTH + IDX_RND, divided by ANG_QUAD through a
  // reciprocal multiply followed by a one-step correction.
  localparam int V_W       = $clog2((ANG_QUAD - 1) * SIN_DEPTH + IDX_RND + 1);
  localparam int RECIP_SH  = V_W;
  localparam longint unsigned RECIP_M = (64'd1 << RECIP_SH) / ANG_QUAD;
  localparam int RECIP_W   = $clog2(RECIP_M + 1);
  localparam int QPROD_W   = V_W + RECIP_W;

  // Table construction constants
  localparam longint unsigned PI_Q30 = 64'd3373259426;
  localparam int TAYLOR_N = 12;
  localparam longint unsigned TAYLOR_DIV [TAYLOR_N] =
    '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
      64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600};
  localparam longint unsigned TAB_DEN = 2 * SIN_DEPTH;

  typedef logic [SIN_DEPTH:0][SIN_W-1:0] sin_tab_t;

  // Integer Taylor series for sin(k * 90deg / SIN_DEPTH), rounded to Q1.15
  function automatic sin_tab_t build_sin_tab();
    sin_tab_t           tab;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic signed [63:0] v;
    for (int k = 0; k <= SIN_DEPTH; k++) begin
      x    = (64'(k) * PI_Q30) / TAB_DEN;
      x2   = (x * x) >> 30;
      term = x;
      sum  = signed'(x);
      for (int n = 1; n <= TAYLOR_N; n++) begin
        term = ((term * x2) >> 30) / TAYLOR_DIV[n-1];
        if ((n & 1) != 0) begin
          sum = sum - signed'(term);
        end else begin
          sum = sum + signed'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      v = (sum + 64'sd16384) >>> 15;
      if (v > 64'sd32768) begin
        v = 64'sd32768;
      end
      tab[k] = v[SIN_W-1:0];
    end
    return tab;
  endfunction

  localparam sin_tab_t SIN_TAB = build_sin_tab();

  // Input command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_SET_X  = 2'd1,
    CMD_SET_Y  = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_code_e;

  // Which angle travels through the trig pipeline
  typedef enum logic [1:0] {
    TS_NONE,
    TS_PITCH,
    TS_SIN_H,
    TS_COS_H
  } trig_sel_e;

  typedef enum logic [3:0] {
    ST_FILL,
    ST_IDLE,
    ST_DECODE,
    ST_ISS_P,
    ST_ISS_S,
    ST_ISS_C,
    ST_WAIT,
    ST_MUL,
    ST_RND,
    ST_UPD,
    ST_OUT
  } ctl_state_e;

  // Controller to datapath
  typedef struct packed {
    logic      fill_en;
    logic      ld_item;
    trig_sel_e trig_sel;
    logic      upd_en;
    logic      out_load;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic fill_done;
    logic is_sample;
    logic trig_done;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/odometry_dead_reckoning_integrator.sv =====
// ----------------------------------------------------------------------------
// odometry_dead_reckoning_integrator
// Dead-reckoning position tracker with set-X / set-Y position loads.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one word per command:
//   a sample (encoder count, heading, pitch) or a set-X / set-Y load.
//   Every word produces exactly one output word on out_valid_o /
//   out_stall_i carrying X, Y and the heading of the last sample.
//   Samples walk three angle lookups through the shared six-stage trig
//   pipeline and its single table read port, then the tilt and
//   projection multiplies; set and no-op words skip them. A word is
//   taken only once the previous one has been handed to the output
//   register.
//   The output register holds the result while the receiver stalls; the
//   next word is accepted meanwhile and waits for the register to free up.
//   Reset clears position and counters, loads the default distance per
//   count, then loads the 1025-entry sine table RAM with in_stall_o
//   high. Configuration writes (cfg_we_i) are taken at any time
//   and must only be issued while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module odometry_dead_reckoning_integrator (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [odr_pkg::DPC_W-1:0]           cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [odr_pkg::CMD_W-1:0]           command_i,
  input  logic signed [odr_pkg::CNT_W-1:0]    encoder_count_i,
  input  logic [odr_pkg::HD_W-1:0]            heading_i,
  input  logic signed [odr_pkg::PITCH_W-1:0]  pitch_i,
  input  logic signed [odr_pkg::POS_W-1:0]    new_value_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [odr_pkg::POS_W-1:0]    pos_x_o,
  output logic signed [odr_pkg::POS_W-1:0]    pos_y_o,
  output logic [odr_pkg::HD_W-1:0]            heading_out_o
);
  import odr_pkg::*;

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  odr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (dp_sts),
    .cmd_o      (dp_cmd)
  );

  odr_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (dp_cmd),
    .sts_o           (dp_sts),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .command_i       (command_i),
    .encoder_count_i (encoder_count_i),
    .heading_i       (heading_i),
    .pitch_i         (pitch_i),
    .new_value_i     (new_value_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .pos_x_o         (pos_x_o),
    .pos_y_o         (pos_y_o),
    .heading_out_o   (heading_out_o)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/odr_ram.sv =====
// ----------------------------------------------------------------------------
// odr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module odr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1025
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hw/rtl/odr_trig.sv =====
// ----------------------------------------------------------------------------
// odr_trig
// Pipelined sine/cosine lookup for centidegree angles. Reduces the angle,
// splits it into quadrant and remainder, maps it to a table index and reads
// the quarter-wave table. Also loads the table RAM after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module odr_trig (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                fill_en_i,
  output logic                                fill_done_o,
  input  odr_pkg::trig_sel_e                  sel_i,
  input  logic [odr_pkg::ANG_W-1:0]           hd_red_i,
  input  logic [odr_pkg::PITCH_W-1:0]         pabs_i,
  output odr_pkg::trig_sel_e                  tag_o,
  output logic signed [odr_pkg::TRIG_W-1:0]   trig_o
);
  import odr_pkg::*;

  // Table load counter
  logic [ADDR_W-1:0] fill_idx_q, fill_idx_d;
  logic              fill_done;
  logic              ram_we;

  assign fill_done   = (fill_idx_q == ADDR_W'(SIN_DEPTH));
  assign fill_done_o = fill_done;
  assign ram_we      = fill_en_i;
  assign fill_idx_d  = (fill_en_i && !fill_done) ? fill_idx_q + 1'b1 : fill_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_idx_q <= '0;
    end else begin
      fill_idx_q <= fill_idx_d;
    end
  end

  // Stage tags, one per registered pipeline stage
  trig_sel_e tag1_q, tag2_q, tag3_q, tag4_q, tag5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= TS_NONE;
      tag2_q <= TS_NONE;
      tag3_q <= TS_NONE;
      tag4_q <= TS_NONE;
      tag5_q <= TS_NONE;
    end else begin
      tag1_q <= sel_i;
      tag2_q <= tag1_q;
      tag3_q <= tag2_q;
      tag4_q <= tag3_q;
      tag5_q <= tag4_q;
    end
  end

  // Stage 1: pick the angle, cosine adds a quarter turn, reduce below 36000
  logic [ANG_W-1:0] src;
  logic [ANG_W-1:0] a1_d, a1_q;

  always_comb begin
    case (sel_i)
      TS_PITCH: src = ANG_W'(pabs_i) + ANG_W'(ANG_QUAD);
      TS_SIN_H: src = hd_red_i;
      TS_COS_H: src = hd_red_i + ANG_W'(ANG_QUAD);
      default:  src = hd_red_i;
    endcase
    a1_d = (src >= ANG_W'(ANG_FULL)) ? src - ANG_W'(ANG_FULL) : src;
  end

  // Stage 2: quadrant, remainder, index numerator
  logic [1:0]      q2_d, q2_q;
  logic [QR_W-1:0] r2;
  logic [V_W-1:0]  v2_d, v2_q;

  always_comb begin
    if (a1_q >= ANG_W'(ANG_3Q)) begin
      q2_d = 2'd3;
      r2   = QR_W'(a1_q - ANG_W'(ANG_3Q));
    end else if (a1_q >= ANG_W'(ANG_HALF)) begin
      q2_d = 2'd2;
      r2   = QR_W'(a1_q - ANG_W'(ANG_HALF));
    end else if (a1_q >= ANG_W'(ANG_QUAD)) begin
      q2_d = 2'd1;
      r2   = QR_W'(a1_q - ANG_W'(ANG_QUAD));
    end else begin
      q2_d = 2'd0;
      r2   = QR_W'(a1_q);
    end
    v2_d = V_W'(32'(r2) * SIN_DEPTH + IDX_RND);
  end

  // Stage 3: reciprocal multiply
  logic [QPROD_W-1:0] p3_q;
  logic [V_W-1:0]     v3_q;
  logic [1:0]         q3_q;

  // Stage 4: quotient with one-step correction
  logic [ADDR_W-1:0] q0;
  logic [V_W-1:0]    qm;
  logic [V_W-1:0]    rem;
  logic [ADDR_W-1:0] idx4_d, idx4_q;
  logic [1:0]        q4_q;

  always_comb begin
    q0     = ADDR_W'(p3_q >> RECIP_SH);
    qm     = V_W'(32'(q0) * ANG_QUAD);
    rem    = v3_q - qm;
    idx4_d = (rem >= V_W'(ANG_QUAD)) ? q0 + 1'b1 : q0;
  end

  // Stage 5: table read, odd quadrants read the mirrored entry
  logic [ADDR_W-1:0] raddr;
  logic              neg5_q;
  logic [SIN_W-1:0]  rdata;

  assign raddr = q4_q[0] ? ADDR_W'(SIN_DEPTH) - idx4_q : idx4_q;

  always_ff @(posedge clk_i) begin
    a1_q   <= a1_d;
    q2_q   <= q2_d;
    v2_q   <= v2_d;
    p3_q   <= QPROD_W'(v2_q) * QPROD_W'(RECIP_M);
    v3_q   <= v2_q;
    q3_q   <= q2_q;
    idx4_q <= idx4_d;
    q4_q   <= q3_q;
    neg5_q <= q4_q[1];
  end

  odr_ram #(
    .WIDTH (SIN_W),
    .DEPTH (SIN_DEPTH + 1)
  ) u_sin_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (fill_idx_q),
    .wdata_i (SIN_TAB[fill_idx_q]),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Stage 6: sign for the lower half-turn
  logic signed [TRIG_W-1:0] mag;

  assign mag    = signed'({1'b0, rdata});
  assign trig_o = neg5_q ? -mag : mag;
  assign tag_o  = tag5_q;

endmodule

`default_nettype wire

// ===== hw/rtl/odr_dpath.sv =====
// ----------------------------------------------------------------------------
// odr_dpath
// Datapath: input word registers, distance and tilt multiplies, heading
// projection, position state, configuration register and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module odr_dpath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  odr_pkg::dp_cmd_t                    cmd_i,
  output odr_pkg::dp_sts_t                    sts_o,
  input  logic                                cfg_we_i,
  input  logic [odr_pkg::DPC_W-1:0]           cfg_wdata_i,
  input  logic [odr_pkg::CMD_W-1:0]           command_i,
  input  logic signed [odr_pkg::CNT_W-1:0]    encoder_count_i,
  input  logic [odr_pkg::HD_W-1:0]            heading_i,
  input  logic signed [odr_pkg::PITCH_W-1:0]  pitch_i,
  input  logic signed [odr_pkg::POS_W-1:0]    new_value_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [odr_pkg::POS_W-1:0]    pos_x_o,
  output logic signed [odr_pkg::POS_W-1:0]    pos_y_o,
  output logic [odr_pkg::HD_W-1:0]            heading_out_o
);
  import odr_pkg::*;

  // Input word registers
  cmd_code_e          cmd_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [HD_W-1:0]    hd_q;
  logic [ANG_W-1:0]   hd_red_q;
  logic [PITCH_W-1:0] pabs_q;
  logic [POS_W-1:0]   nv_q;

  logic [ANG_W-1:0]   hd_red_d;
  logic [PITCH_W-1:0] pabs_d;

  assign hd_red_d = (heading_i >= HD_W'(ANG_FULL)) ? heading_i - HD_W'(ANG_FULL) : heading_i;
  assign pabs_d   = pitch_i[PITCH_W-1] ? PITCH_W'(~pitch_i + 1'b1) : pitch_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_item) begin
      cmd_q    <= cmd_code_e'(command_i);
      cnt_q    <= encoder_count_i;
      hd_q     <= heading_i;
      hd_red_q <= hd_red_d;
      pabs_q   <= pabs_d;
      nv_q     <= new_value_i;
    end
  end

  // Configuration and tracker state
  logic [DPC_W-1:0] dpc_q;
  logic [POS_W-1:0] x_q, x_d;
  logic [POS_W-1:0] y_q, y_d;
  logic [CNT_W-1:0] last_cnt_q, last_cnt_d;
  logic [HD_W-1:0]  last_hd_q, last_hd_d;

  // Trig results
  trig_sel_e                trig_tag;
  logic signed [TRIG_W-1:0] trig_val;
  logic signed [TRIG_W-1:0] cos_p_q, sin_h_q, cos_h_q;
  logic                     fill_done;

  odr_trig u_trig (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fill_en_i   (cmd_i.fill_en),
    .fill_done_o (fill_done),
    .sel_i       (cmd_i.trig_sel),
    .hd_red_i    (hd_red_q),
    .pabs_i      (pabs_q),
    .tag_o       (trig_tag),
    .trig_o      (trig_val)
  );

  always_ff @(posedge clk_i) begin
    case (trig_tag)
      TS_PITCH: cos_p_q <= trig_val;
      TS_SIN_H: sin_h_q <= trig_val;
      TS_COS_H: cos_h_q <= trig_val;
      default:  ;
    endcase
  end

  // Distance: wrapped count delta times distance per count, round >> 16
  logic signed [CNT_W-1:0]  diff;
  logic signed [DPC_W:0]    dpc_s;
  logic signed [64:0]       mul_dist;
  logic signed [63:0]       dist_prod_q;
  logic signed [POS_W-1:0]  dist_q;

  assign diff     = signed'(cnt_q - last_cnt_q);
  assign dpc_s    = signed'({1'b0, dpc_q});
  assign mul_dist = diff * dpc_s;

  // Tilt by cos(pitch), then project on the heading
  logic signed [64:0]      mul_tilt;
  logic signed [63:0]      tilt_prod_q;
  logic signed [POS_W-1:0] tilt_q;
  logic signed [64:0]      mul_dx, mul_dy;
  logic signed [63:0]      dx_prod_q, dy_prod_q;
  logic signed [POS_W-1:0] dx_q, dy_q;

  assign mul_tilt = dist_q * cos_p_q;
  assign mul_dx   = tilt_q * sin_h_q;
  assign mul_dy   = tilt_q * cos_h_q;

  always_ff @(posedge clk_i) begin
    dist_prod_q <= mul_dist[63:0];
    dist_q      <= POS_W'((dist_prod_q + 64'sd32768) >>> 16);
    tilt_prod_q <= mul_tilt[63:0];
    tilt_q      <= POS_W'((tilt_prod_q + 64'sd16384) >>> 15);
    dx_prod_q   <= mul_dx[63:0];
    dy_prod_q   <= mul_dy[63:0];
    dx_q        <= POS_W'((dx_prod_q + 64'sd16384) >>> 15);
    dy_q        <= POS_W'((dy_prod_q + 64'sd16384) >>> 15);
  end

  // State update per command
  always_comb begin
    x_d        = x_q;
    y_d        = y_q;
    last_cnt_d = last_cnt_q;
    last_hd_d  = last_hd_q;
    if (cmd_i.upd_en) begin
      case (cmd_q)
        CMD_SAMPLE: begin
          x_d        = x_q + dx_q;
          y_d        = y_q + dy_q;
          last_cnt_d = cnt_q;
          last_hd_d  = hd_q;
        end
        CMD_SET_X: x_d = nv_q;
        CMD_SET_Y: y_d = nv_q;
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dpc_q      <= DPC_RESET;
      x_q        <= '0;
      y_q        <= '0;
      last_cnt_q <= '0;
      last_hd_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        dpc_q <= cfg_wdata_i;
      end
      x_q        <= x_d;
      y_q        <= y_d;
      last_cnt_q <= last_cnt_d;
      last_hd_q  <= last_hd_d;
    end
  end

  // Output register
  logic              out_valid_q;
  logic [POS_W-1:0]  out_x_q, out_y_q;
  logic [HD_W-1:0]   out_hd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_x_q  <= x_q;
      out_y_q  <= y_q;
      out_hd_q <= last_hd_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pos_x_o       = signed'(out_x_q);
  assign pos_y_o       = signed'(out_y_q);
  assign heading_out_o = out_hd_q;

  // Status
  assign sts_o.fill_done = fill_done;
  assign sts_o.is_sample = (cmd_q == CMD_SAMPLE);
  assign sts_o.trig_done = (trig_tag == TS_COS_H);
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

endmodule

`default_nettype wire

// ===== hw/rtl/odr_ctrl.sv =====
// ----------------------------------------------------------------------------
// odr_ctrl
// Sequencer: table load after reset, word acceptance, trig issue order,
// multiply wait states, state commit and output handoff.
// ----------------------------------------------------------------------------
`default_nettype none

module odr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  odr_pkg::dp_sts_t  sts_i,
  output odr_pkg::dp_cmd_t  cmd_o
);
  import odr_pkg::*;

  ctl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_FILL;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_FILL:   if (sts_i.fill_done) state_d = ST_IDLE;
      ST_IDLE:   if (in_valid_i) state_d = ST_DECODE;
      ST_DECODE: state_d = sts_i.is_sample ? ST_ISS_P : ST_UPD;
      ST_ISS_P:  state_d = ST_ISS_S;
      ST_ISS_S:  state_d = ST_ISS_C;
      ST_ISS_C:  state_d = ST_WAIT;
      ST_WAIT:   if (sts_i.trig_done) state_d = ST_MUL;
      ST_MUL:    state_d = ST_RND;
      ST_RND:    state_d = ST_UPD;
      ST_UPD:    state_d = ST_OUT;
      ST_OUT:    if (sts_i.out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o.fill_en  = (state_q == ST_FILL);
    cmd_o.ld_item  = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.upd_en   = (state_q == ST_UPD);
    cmd_o.out_load = (state_q == ST_OUT) && sts_i.out_free;
    case (state_q)
      ST_ISS_P: cmd_o.trig_sel = TS_PITCH;
      ST_ISS_S: cmd_o.trig_sel = TS_SIN_H;
      ST_ISS_C: cmd_o.trig_sel = TS_COS_H;
      default:  cmd_o.trig_sel = TS_NONE;
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

`default_nettype wire
